FILE: rtl/mgb_pkg.sv
// ============================================================================
// mgb_pkg: shared types and constants of the maze generator
// Action codes, direction and wall codes, the cell word layout, the
// controller states and the neighbor pick result.
// ============================================================================
package mgb_pkg;

    // Action codes carried in the input item's tuser.
    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_STEP    = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // Carve directions. A direction's number is also the bit of its wall.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // Wall bits of a cell.
    localparam logic [3:0] WALL_TOP    = 4'b0001;
    localparam logic [3:0] WALL_RIGHT  = 4'b0010;
    localparam logic [3:0] WALL_BOTTOM = 4'b0100;
    localparam logic [3:0] WALL_LEFT   = 4'b1000;
    localparam logic [3:0] WALL_ALL    = 4'b1111;

    // Cell word: visited flag above the four wall bits.
    localparam int CELL_W   = 5;
    localparam int VIS_BIT  = 4;

    // Configuration register indexes and their reset value.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam int   CFG_W      = 7;
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int COORD_W     = 6;

    // Controller states, one-hot.
    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_INIT0  = 17'h00004,
        S_TOP_RD = 17'h00008,
        S_TOP    = 17'h00010,
        S_NB     = 17'h00020,
        S_PICK   = 17'h00040,
        S_C0     = 17'h00080,
        S_C1     = 17'h00100,
        S_C2     = 17'h00200,
        S_X0     = 17'h00400,
        S_X1     = 17'h00800,
        S_X2     = 17'h01000,
        S_X3     = 17'h02000,
        S_Q0     = 17'h04000,
        S_Q1     = 17'h08000,
        S_EMIT   = 17'h10000
    } state_t;

    // Outcome of the neighbor choice.
    typedef struct packed {
        logic       found;
        logic [1:0] dir;
    } pick_t;

    // Remainder of a byte by three: base-four digits sum up modulo three.
    function automatic logic [1:0] mod3_u8(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

FILE: rtl/mgb_ram.sv
// ============================================================================
// mgb_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ============================================================================
module mgb_ram #(
    parameter int DATA_W = 5,
    parameter int DEPTH  = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mgb_pick.sv
// ============================================================================
// mgb_pick: neighbor choice
// Takes the unvisited-neighbor mask and the random byte, and returns the
// direction of entry (random mod count) in the order up, right, down, left.
// ============================================================================
module mgb_pick (
    input  logic [3:0]     unvisited,
    input  logic [7:0]     random_value,
    output mgb_pkg::pick_t pick
);

    logic [2:0] count;
    logic [1:0] index;

    assign count = 3'($countones(unvisited));

    always_comb
    begin
        case (count)
            3'd2:    index = {1'b0, random_value[0]};
            3'd3:    index = mgb_pkg::mod3_u8(random_value);
            3'd4:    index = random_value[1:0];
            default: index = 2'd0;
        endcase
    end

    // Walk the mask and stop at the set bit whose rank equals the index.
    always_comb
    begin
        logic [2:0] rank;
        rank = 3'd0;
        pick.found = (count != 3'd0);
        pick.dir = mgb_pkg::DIR_UP;
        for (int i = 0; i < 4; i++)
        begin
            if (unvisited[i])
            begin
                if (rank == {1'b0, index})
                begin
                    pick.dir = 2'(i);
                end
                rank = rank + 3'd1;
            end
        end
    end

endmodule

FILE: rtl/maze_generator_backtracker_unit.sv
// ============================================================================
// maze_generator_backtracker_unit: depth-first maze carver
// Builds a perfect maze by recursive backtracking with an explicit stack,
// one carve per step item, and answers wall reads of single cells.
// ============================================================================
// The block works on one item at a time; every item gives exactly one result
// item, and a new item is taken while the previous result still waits at the
// output register. Cell state (visited flag and four walls) lives in one
// memory of MAX_WIDTH*MAX_HEIGHT words and the path stack in a second one,
// both with a single registered read port, and that read port sets the
// timing. A read item reads its cell and then loads the result. A step
// item that carves reads the stack top and the four neighbors, picks one,
// then updates the current and the carved cell and pushes the latter; it
// first pops each dead-end cell and each stacked cell outside the current
// maze size. The step that empties the stack opens the exit instead. A
// restart sweeps the whole cell memory, one word a cycle; the same sweep
// runs after reset, during which s_tready stays low. Configuration writes
// are taken at any time (cfg_ready is always high) but are meant to land
// only while the block is idle. Sizes below 2 or above the maximum are
// saturated. Before the first restart and after a maze is finished, step
// items report finished and change nothing.
// ============================================================================
module maze_generator_backtracker_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: random_value[7:0], query_x[13:8], query_y[19:14], zero fill
    input  logic [mgb_pkg::IN_TDATA_W-1:0]      s_tdata,
    // s_tuser: action[1:0]
    input  logic [1:0]                          s_tuser,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: carved[0], from_x[6:1], from_y[12:7], direction[14:13],
    //          finished[15], wall_bits[19:16], zero fill
    output logic [mgb_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [mgb_pkg::CFG_W-1:0]           cfg_data
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int SW    = XW + YW;
    localparam int DXW   = $clog2(MAX_WIDTH + 1);
    localparam int DYW   = $clog2(MAX_HEIGHT + 1);
    localparam int CXW   = (DXW > mgb_pkg::CFG_W) ? DXW : mgb_pkg::CFG_W;
    localparam int CYW   = (DYW > mgb_pkg::CFG_W) ? DYW : mgb_pkg::CFG_W;
    localparam int DPW   = $clog2(CELLS + 1);
    localparam int CW    = mgb_pkg::CELL_W;

    // Control state.
    mgb_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            restart_reg, restart_next;
    logic [DPW-1:0]  depth_reg, depth_next;
    logic            done_reg, done_next;
    logic [2:0]      k_reg, k_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [mgb_pkg::CFG_W-1:0] width_cfg_reg, width_cfg_next;
    logic [mgb_pkg::CFG_W-1:0] height_cfg_reg, height_cfg_next;

    // Item payload and working registers.
    logic [7:0]      rv_reg, rv_next;
    logic [mgb_pkg::COORD_W-1:0] qx_reg, qx_next;
    logic [mgb_pkg::COORD_W-1:0] qy_reg, qy_next;
    logic [XW-1:0]   cx_reg, cx_next;
    logic [YW-1:0]   cy_reg, cy_next;
    logic [AW-1:0]   caddr_reg, caddr_next;
    logic [3:0]      unv_reg, unv_next;
    logic [1:0]      dir_reg, dir_next;
    logic            res_carved_reg, res_carved_next;
    logic [mgb_pkg::COORD_W-1:0] res_fx_reg, res_fx_next;
    logic [mgb_pkg::COORD_W-1:0] res_fy_reg, res_fy_next;
    logic [1:0]      res_dir_reg, res_dir_next;
    logic [3:0]      res_wall_reg, res_wall_next;
    logic [mgb_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Memory ports.
    logic            cell_we, cell_re;
    logic [AW-1:0]   cell_waddr, cell_raddr;
    logic [CW-1:0]   cell_wdata, cell_rdata;
    logic            stk_we, stk_re;
    logic [AW-1:0]   stk_waddr, stk_raddr;
    logic [SW-1:0]   stk_wdata, stk_rdata;

    // Derived values.
    logic [CXW-1:0]  w_raw;
    logic [CYW-1:0]  h_raw;
    logic [DXW-1:0]  w_c;
    logic [DYW-1:0]  h_c;
    logic [XW-1:0]   top_x;
    logic [YW-1:0]   top_y;
    logic            top_in;
    logic [3:0]      nb_ok;
    logic [AW-1:0]   nb_addr [4];
    logic [AW-1:0]   carve_addr;
    logic [XW-1:0]   carve_x;
    logic [YW-1:0]   carve_y;
    logic [3:0]      dir_mask;
    logic [3:0]      opp_mask;
    logic [AW-1:0]   exit_addr;
    logic            q_in;
    logic [AW-1:0]   q_addr;
    logic [1:0]      k_prev;
    mgb_pkg::pick_t  pick;

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
        return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
    endfunction

    mgb_ram #(
        .DATA_W (CW),
        .DEPTH  (CELLS)
    ) u_cell_mem (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    mgb_ram #(
        .DATA_W (SW),
        .DEPTH  (CELLS)
    ) u_stack_mem (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    mgb_pick u_pick (
        .unvisited    (unv_reg),
        .random_value (rv_reg),
        .pick         (pick)
    );

    // Saturate the configured sizes to 2..MAX.
    assign w_raw = CXW'(width_cfg_reg);
    assign h_raw = CYW'(height_cfg_reg);

    always_comb
    begin
        if (w_raw < CXW'(2))
        begin
            w_c = DXW'(2);
        end
        else if (w_raw > CXW'(MAX_WIDTH))
        begin
            w_c = DXW'(MAX_WIDTH);
        end
        else
        begin
            w_c = DXW'(w_raw);
        end
        if (h_raw < CYW'(2))
        begin
            h_c = DYW'(2);
        end
        else if (h_raw > CYW'(MAX_HEIGHT))
        begin
            h_c = DYW'(MAX_HEIGHT);
        end
        else
        begin
            h_c = DYW'(h_raw);
        end
    end

    // The stack top as it comes out of the stack memory.
    assign top_x  = stk_rdata[XW-1:0];
    assign top_y  = stk_rdata[SW-1:XW];
    assign top_in = (DXW'(top_x) < w_c) && (DYW'(top_y) < h_c);

    // Which neighbors of the current cell lie inside the maze.
    assign nb_ok[mgb_pkg::DIR_UP]    = (cy_reg != '0);
    assign nb_ok[mgb_pkg::DIR_RIGHT] = (DXW'(cx_reg) + DXW'(1)) < w_c;
    assign nb_ok[mgb_pkg::DIR_DOWN]  = (DYW'(cy_reg) + DYW'(1)) < h_c;
    assign nb_ok[mgb_pkg::DIR_LEFT]  = (cx_reg != '0);

    assign nb_addr[mgb_pkg::DIR_UP]    = caddr_reg - AW'(MAX_WIDTH);
    assign nb_addr[mgb_pkg::DIR_RIGHT] = caddr_reg + AW'(1);
    assign nb_addr[mgb_pkg::DIR_DOWN]  = caddr_reg + AW'(MAX_WIDTH);
    assign nb_addr[mgb_pkg::DIR_LEFT]  = caddr_reg - AW'(1);

    assign carve_addr = nb_addr[dir_reg];
    assign dir_mask   = 4'b0001 << dir_reg;
    assign opp_mask   = 4'b0001 << (dir_reg + 2'd2);
    assign k_prev     = 2'(k_reg - 3'd1);

    always_comb
    begin
        carve_x = cx_reg;
        carve_y = cy_reg;
        case (dir_reg)
            mgb_pkg::DIR_UP:    carve_y = cy_reg - YW'(1);
            mgb_pkg::DIR_RIGHT: carve_x = cx_reg + XW'(1);
            mgb_pkg::DIR_DOWN:  carve_y = cy_reg + YW'(1);
            default:            carve_x = cx_reg - XW'(1);
        endcase
    end

    // Exit cell sits in the bottom-right corner.
    assign exit_addr = cell_addr(XW'(w_c - DXW'(1)), YW'(h_c - DYW'(1)));

    assign q_in   = (CXW'(qx_reg) < CXW'(w_c)) && (CYW'(qy_reg) < CYW'(h_c));
    assign q_addr = cell_addr(XW'(qx_reg), YW'(qy_reg));

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        restart_next    = restart_reg;
        depth_next      = depth_reg;
        done_next       = done_reg;
        k_next          = k_reg;
        m_tvalid_next   = m_tvalid_reg;
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        rv_next         = rv_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        caddr_next      = caddr_reg;
        unv_next        = unv_reg;
        dir_next        = dir_reg;
        res_carved_next = res_carved_reg;
        res_fx_next     = res_fx_reg;
        res_fy_next     = res_fy_reg;
        res_dir_next    = res_dir_reg;
        res_wall_next   = res_wall_reg;
        m_tdata_next    = m_tdata_reg;
        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = '0;
        cell_re    = 1'b0;
        cell_raddr = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_re     = 1'b0;
        stk_raddr  = '0;

        if (cfg_valid)
        begin
            if (cfg_index == mgb_pkg::REG_WIDTH)
            begin
                width_cfg_next = cfg_data;
            end
            else
            begin
                height_cfg_next = cfg_data;
            end
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            mgb_pkg::S_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_reg;
                cell_wdata = {1'b0, mgb_pkg::WALL_ALL};
                if (clr_reg == AW'(CELLS - 1))
                begin
                    state_next = restart_reg ? mgb_pkg::S_INIT0 : mgb_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            mgb_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    rv_next         = s_tdata[7:0];
                    qx_next         = s_tdata[13:8];
                    qy_next         = s_tdata[19:14];
                    res_carved_next = 1'b0;
                    res_fx_next     = '0;
                    res_fy_next     = '0;
                    res_dir_next    = '0;
                    res_wall_next   = '0;
                    unique case (s_tuser)
                        mgb_pkg::ACT_RESTART:
                        begin
                            restart_next = 1'b1;
                            clr_next     = '0;
                            state_next   = mgb_pkg::S_CLEAR;
                        end
                        mgb_pkg::ACT_STEP:
                        begin
                            state_next = done_reg ? mgb_pkg::S_EMIT : mgb_pkg::S_TOP_RD;
                        end
                        mgb_pkg::ACT_READ:
                        begin
                            state_next = mgb_pkg::S_Q0;
                        end
                        default:
                        begin
                            state_next = mgb_pkg::S_EMIT;
                        end
                    endcase
                end
            end
            mgb_pkg::S_INIT0:
            begin
                // Start cell (0,0) is visited and is the only stack entry.
                cell_we    = 1'b1;
                cell_waddr = '0;
                cell_wdata = {1'b1, mgb_pkg::WALL_ALL};
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = '0;
                depth_next = DPW'(1);
                done_next  = 1'b0;
                state_next = mgb_pkg::S_EMIT;
            end
            mgb_pkg::S_TOP_RD:
            begin
                if (depth_reg == '0)
                begin
                    state_next = mgb_pkg::S_X0;
                end
                else
                begin
                    stk_re     = 1'b1;
                    stk_raddr  = AW'(depth_reg - DPW'(1));
                    state_next = mgb_pkg::S_TOP;
                end
            end
            mgb_pkg::S_TOP:
            begin
                if (top_in)
                begin
                    cx_next    = top_x;
                    cy_next    = top_y;
                    caddr_next = cell_addr(top_x, top_y);
                    k_next     = '0;
                    unv_next   = '0;
                    state_next = mgb_pkg::S_NB;
                end
                else
                begin
                    // A cell outside the current size has no neighbors.
                    depth_next = depth_reg - DPW'(1);
                    state_next = mgb_pkg::S_TOP_RD;
                end
            end
            mgb_pkg::S_NB:
            begin
                // Read neighbor k while the visited flag of neighbor k-1 arrives.
                if (!k_reg[2])
                begin
                    cell_re    = 1'b1;
                    cell_raddr = nb_addr[k_reg[1:0]];
                end
                if (k_reg != '0)
                begin
                    unv_next[k_prev] = nb_ok[k_prev] & ~cell_rdata[mgb_pkg::VIS_BIT];
                end
                if (k_reg[2])
                begin
                    state_next = mgb_pkg::S_PICK;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            mgb_pkg::S_PICK:
            begin
                if (pick.found)
                begin
                    dir_next   = pick.dir;
                    state_next = mgb_pkg::S_C0;
                end
                else
                begin
                    depth_next = depth_reg - DPW'(1);
                    state_next = mgb_pkg::S_TOP_RD;
                end
            end
            mgb_pkg::S_C0:
            begin
                cell_re    = 1'b1;
                cell_raddr = caddr_reg;
                state_next = mgb_pkg::S_C1;
            end
            mgb_pkg::S_C1:
            begin
                cell_we    = 1'b1;
                cell_waddr = caddr_reg;
                cell_wdata = {cell_rdata[mgb_pkg::VIS_BIT], cell_rdata[3:0] & ~dir_mask};
                cell_re    = 1'b1;
                cell_raddr = carve_addr;
                state_next = mgb_pkg::S_C2;
            end
            mgb_pkg::S_C2:
            begin
                cell_we    = 1'b1;
                cell_waddr = carve_addr;
                cell_wdata = {1'b1, cell_rdata[3:0] & ~opp_mask};
                if (depth_reg < DPW'(CELLS))
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = depth_reg[AW-1:0];
                    stk_wdata  = {carve_y, carve_x};
                    depth_next = depth_reg + DPW'(1);
                end
                res_carved_next = 1'b1;
                res_fx_next     = mgb_pkg::COORD_W'(cx_reg);
                res_fy_next     = mgb_pkg::COORD_W'(cy_reg);
                res_dir_next    = dir_reg;
                state_next      = mgb_pkg::S_EMIT;
            end
            mgb_pkg::S_X0:
            begin
                cell_re    = 1'b1;
                cell_raddr = exit_addr;
                state_next = mgb_pkg::S_X1;
            end
            mgb_pkg::S_X1:
            begin
                cell_we    = 1'b1;
                cell_waddr = exit_addr;
                cell_wdata = cell_rdata & ~{1'b0, mgb_pkg::WALL_LEFT | mgb_pkg::WALL_TOP};
                cell_re    = 1'b1;
                cell_raddr = exit_addr - AW'(1);
                state_next = mgb_pkg::S_X2;
            end
            mgb_pkg::S_X2:
            begin
                cell_we    = 1'b1;
                cell_waddr = exit_addr - AW'(1);
                cell_wdata = cell_rdata & ~{1'b0, mgb_pkg::WALL_RIGHT};
                cell_re    = 1'b1;
                cell_raddr = exit_addr - AW'(MAX_WIDTH);
                state_next = mgb_pkg::S_X3;
            end
            mgb_pkg::S_X3:
            begin
                cell_we    = 1'b1;
                cell_waddr = exit_addr - AW'(MAX_WIDTH);
                cell_wdata = cell_rdata & ~{1'b0, mgb_pkg::WALL_BOTTOM};
                done_next  = 1'b1;
                state_next = mgb_pkg::S_EMIT;
            end
            mgb_pkg::S_Q0:
            begin
                cell_re    = 1'b1;
                cell_raddr = q_addr;
                state_next = mgb_pkg::S_Q1;
            end
            mgb_pkg::S_Q1:
            begin
                res_wall_next = q_in ? cell_rdata[3:0] : 4'b0000;
                state_next    = mgb_pkg::S_EMIT;
            end
            mgb_pkg::S_EMIT:
            begin
                // The output register is free or is being emptied this cycle.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {4'b0000, res_wall_reg, done_reg, res_dir_reg,
                                     res_fy_reg, res_fx_reg, res_carved_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = mgb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mgb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mgb_pkg::S_CLEAR;
            clr_reg        <= '0;
            restart_reg    <= 1'b0;
            depth_reg      <= '0;
            done_reg       <= 1'b1;
            k_reg          <= '0;
            m_tvalid_reg   <= 1'b0;
            width_cfg_reg  <= mgb_pkg::CFG_DIM_RESET;
            height_cfg_reg <= mgb_pkg::CFG_DIM_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            restart_reg    <= restart_next;
            depth_reg      <= depth_next;
            done_reg       <= done_next;
            k_reg          <= k_next;
            m_tvalid_reg   <= m_tvalid_next;
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg         <= rv_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        caddr_reg      <= caddr_next;
        unv_reg        <= unv_next;
        dir_reg        <= dir_next;
        res_carved_reg <= res_carved_next;
        res_fx_reg     <= res_fx_next;
        res_fy_reg     <= res_fy_next;
        res_dir_reg    <= res_dir_next;
        res_wall_reg   <= res_wall_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready  = (state_reg == mgb_pkg::S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // The cell memory is never read and written at the same word in one cycle,
    // so no forwarding path is needed.
    a_no_cell_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_we && cell_re) |-> (cell_waddr != cell_raddr))
        else $error("cell memory read and write hit the same word");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DPW'(CELLS))
        else $error("stack depth beyond the cell count");

    // A finished or never started maze has an empty stack.
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (depth_reg == '0))
        else $error("finished flag set with cells left on the stack");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mgb_pkg::S_EMIT) && (!m_tvalid_reg || m_tready))
        |=> (m_tvalid_reg && (state_reg == mgb_pkg::S_IDLE)))
        else $error("result not loaded into the output register");

endmodule
